// ===== hw/rtl/indexed_ordered_list_core_defines.svh =====
// Assertion macros shared by the indexed ordered list RTL.
// Used by files that carry concurrent checks; no other dependencies.
`ifndef INDEXED_ORDERED_LIST_CORE_DEFINES_SVH
`define INDEXED_ORDERED_LIST_CORE_DEFINES_SVH

// Condition holds at every clock edge outside reset.
`define IOL_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define IOL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define IOL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/iol_pkg.sv =====
// Types and codes of the indexed ordered list core.
// No dependencies; imported by every module of the block but the RAM.
package iol_pkg;

	typedef enum logic [2:0] {
		OP_FRONT      = 3'd0,
		OP_APPEND     = 3'd1,
		OP_AFTER      = 3'd2,
		OP_READ       = 3'd3,
		OP_DROP_FIRST = 3'd4,
		OP_DROP_LAST  = 3'd5,
		OP_DROP_AT    = 3'd6,
		OP_CLEAR      = 3'd7
	} op_e_t;

	typedef enum logic [1:0] {
		STAT_DONE = 2'd0,
		STAT_FULL = 2'd1,
		STAT_NONE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_NOOP   = 2'd0,
		K_INSERT = 2'd1,
		K_REMOVE = 2'd2,
		K_READ   = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'd0,
		S_EXEC = 3'd1,
		S_MOVE = 3'd2,
		S_PUT  = 3'd3,
		S_READ = 3'd4,
		S_DONE = 3'd5
	} state_t;

	typedef struct packed {
		op_e_t              operation;
		logic [5:0]         position;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               found;
		logic [6:0]         count;
		status_t            status;
	} rsp_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic rd_pos;
		logic put;
		logic cap_read;
		logic emit;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		kind_t kind;
		logic  moves_zero;
		logic  out_free;
	} dp_stat_t;

endpackage

// ===== hw/rtl/iol_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iol_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== hw/rtl/iol_datapath.sv =====
// Datapath of the indexed ordered list: element RAM, count, shift pointers
// and result register. Depends on iol_pkg, iol_ram and the assertion macros.
`include "indexed_ordered_list_core_defines.svh"

module iol_datapath #(
	parameter int CAPACITY = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  iol_pkg::req_t     req,
	output iol_pkg::rsp_t     rsp,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	input  iol_pkg::ctl_cmd_t cmd,
	output iol_pkg::dp_stat_t stat
);

	import iol_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 6) ? CW : 6;

	logic [CW-1:0]      cnt_q;
	logic [5:0]         pos_q;
	logic signed [31:0] val_q;
	kind_t              kind_q;
	logic               dir_up_q;
	logic [AW-1:0]      at_q;
	logic [AW-1:0]      src_q;
	logic [CW-1:0]      moves_q;
	logic signed [31:0] rv_q;
	logic               found_q;
	status_t            st_q;
	logic               out_valid_q;
	rsp_t               rsp_q;
	logic               wr_pend_s1;
	logic [AW-1:0]      wr_addr_s1;

	logic [XW-1:0]      pos_x;
	logic [XW-1:0]      cnt_x;
	logic               in_range;
	logic               full;
	logic               empty;
	kind_t              l_kind;
	logic [CW-1:0]      l_at;
	logic [CW-1:0]      l_cnt;
	logic [CW-1:0]      l_moves;
	logic [CW-1:0]      l_src;
	status_t            l_stat;
	logic signed [31:0] l_rv;
	logic [CW+6:0]      cnt_wide;

	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [31:0]        ram_wdata;
	logic               ram_re;
	logic [AW-1:0]      ram_raddr;
	logic [31:0]        ram_rdata;

	// Classify the incoming operation against the current count
	always_comb begin
		pos_x    = XW'(req.position);
		cnt_x    = XW'(cnt_q);
		in_range = pos_x < cnt_x;
		full     = cnt_q == CW'(CAPACITY);
		empty    = cnt_q == '0;
		l_kind   = K_NOOP;
		l_at     = '0;
		l_cnt    = cnt_q;
		l_stat   = STAT_DONE;
		l_rv     = '0;
		case (req.operation)
			OP_FRONT, OP_APPEND, OP_AFTER: begin
				if (full) begin
					l_stat = STAT_FULL;
				end else begin
					l_kind = K_INSERT;
					l_cnt  = cnt_q + CW'(1);
					case (req.operation)
						OP_FRONT:  l_at = '0;
						OP_APPEND: l_at = cnt_q;
						default:   l_at = in_range ? CW'(pos_x + XW'(1)) : cnt_q;
					endcase
				end
			end
			OP_READ: begin
				if (in_range) begin
					l_kind = K_READ;
				end else begin
					l_stat = STAT_NONE;
					l_rv   = '1;	// absent position reads as minus one
				end
			end
			OP_DROP_FIRST: begin
				if (empty) begin
					l_stat = STAT_NONE;
				end else begin
					l_kind = K_REMOVE;
					l_cnt  = cnt_q - CW'(1);
				end
			end
			OP_DROP_LAST: begin
				if (empty) begin
					l_stat = STAT_NONE;
				end else begin
					l_kind = K_REMOVE;
					l_at   = cnt_q - CW'(1);
					l_cnt  = cnt_q - CW'(1);
				end
			end
			OP_DROP_AT: begin
				if (in_range) begin
					l_kind = K_REMOVE;
					l_at   = CW'(pos_x);
					l_cnt  = cnt_q - CW'(1);
				end else begin
					l_stat = STAT_NONE;
				end
			end
			OP_CLEAR: begin
				l_cnt = '0;
			end
			default: begin
				l_cnt = cnt_q;
			end
		endcase
		// Insert moves entries at..cnt-1 up; remove moves at+1..cnt-1 down
		if (l_kind == K_INSERT) begin
			l_moves = cnt_q - l_at;
			l_src   = cnt_q - CW'(1);
		end else if (l_kind == K_REMOVE) begin
			l_moves = cnt_q - CW'(1) - l_at;
			l_src   = l_at + CW'(1);
		end else begin
			l_moves = '0;
			l_src   = '0;
		end
	end

	// Element count, shift control, the write pipeline and the result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			kind_q      <= K_NOOP;
			moves_q     <= '0;
			wr_pend_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wr_pend_s1 <= cmd.step;
			if (cmd.load) begin
				cnt_q   <= l_cnt;
				kind_q  <= l_kind;
				moves_q <= l_moves;
			end else if (cmd.step) begin
				moves_q <= moves_q - CW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Operands, pointers and result fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q    <= req.position;
			val_q    <= req.value;
			dir_up_q <= l_kind == K_INSERT;
			at_q     <= AW'(l_at);
			src_q    <= AW'(l_src);
			rv_q     <= l_rv;
			found_q  <= 1'b0;
			st_q     <= l_stat;
		end
		if (cmd.step) begin
			src_q      <= dir_up_q ? src_q - AW'(1) : src_q + AW'(1);
			wr_addr_s1 <= dir_up_q ? src_q + AW'(1) : src_q - AW'(1);
		end
		if (cmd.cap_read) begin
			rv_q    <= ram_rdata;
			found_q <= 1'b1;
		end
		if (cmd.emit) begin
			rsp_q.read_value <= rv_q;
			rsp_q.found      <= found_q;
			rsp_q.count      <= cnt_wide[6:0];
			rsp_q.status     <= st_q;
		end
	end

	// Count reported modulo 128
	assign cnt_wide = (CW + 7)'(cnt_q);

	// Memory port steering: moved data or the new value on write
	assign ram_we    = wr_pend_s1 | cmd.put;
	assign ram_waddr = cmd.put ? at_q : wr_addr_s1;
	assign ram_wdata = cmd.put ? val_q : ram_rdata;
	assign ram_re    = cmd.step | cmd.rd_pos;
	assign ram_raddr = cmd.step ? src_q : AW'(pos_q);

	iol_ram #(
		.WIDTH(32),
		.DEPTH(CAPACITY)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign stat.kind       = kind_q;
	assign stat.moves_zero = moves_q == '0;
	assign stat.out_free   = !out_valid_q || !rsp_stall;

	assign rsp       = rsp_q;
	assign rsp_valid = out_valid_q;

	`IOL_ASSERT_ALWAYS(a_cnt_cap, clk, arst_n, cnt_q <= CW'(CAPACITY), "count above capacity")
	`IOL_ASSERT_IMP(a_wr_collide, clk, arst_n, cmd.put, !wr_pend_s1, "value write overlaps move")
	`IOL_ASSERT_IMP(a_rd_range, clk, arst_n, cmd.rd_pos, XW'(pos_q) < XW'(cnt_q), "read out of range")
	`IOL_ASSERT_IMP(a_full_cnt, clk, arst_n, cmd.emit && st_q == STAT_FULL, cnt_q == CW'(CAPACITY), "full status with room left")

endmodule

// ===== hw/rtl/iol_ctrl.sv =====
// Controller state machine of the indexed ordered list.
// Depends on iol_pkg; drives the datapath commands and the request stall.
module iol_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  iol_pkg::dp_stat_t stat,
	output iol_pkg::ctl_cmd_t cmd
);

	import iol_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_stall = state_q != S_IDLE;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (stat.kind)
					K_INSERT, K_REMOVE: state_d = S_MOVE;
					K_READ: begin
						cmd.rd_pos = 1'b1;
						state_d    = S_READ;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_MOVE: begin
				// advance one element a cycle until the gap is opened or closed
				if (!stat.moves_zero) begin
					cmd.step = 1'b1;
				end else if (stat.kind == K_INSERT) begin
					state_d = S_PUT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_PUT: begin
				cmd.put = 1'b1;
				state_d = S_DONE;
			end
			S_READ: begin
				cmd.cap_read = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				// hold until the result register is free
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/indexed_ordered_list_core.sv =====
// Indexed ordered list core: one result per request, one request at a time.
// A new request is stalled until the last result is loaded into the result register.
// Clear and rejected requests go straight to the result, a read first reads the RAM, a
// remove shifts moves elements down, an insert shifts moves elements up, then writes
// the new value; moves is the number of stored elements shifted one per cycle in RAM.
// Reset (arst_n, async low) empties the list; stored elements are not cleared.
module indexed_ordered_list_core #(
	parameter int CAPACITY = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  iol_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output iol_pkg::rsp_t rsp
);

	import iol_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	iol_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	iol_datapath #(
		.CAPACITY(CAPACITY)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.cmd      (cmd),
		.stat     (stat)
	);

endmodule

// ===== tb/sv/tb_indexed_ordered_list_core.sv =====
`timescale 1ns / 100ps
// Self-checking bench for indexed_ordered_list_core: directed and random list operations,
// each result checked against a shadow list kept by a small scoreboard class.
// Depends on iol_pkg and the core RTL only.
module tb_indexed_ordered_list_core;
	import iol_pkg::*;

	localparam int CAP          = 64;
	localparam int RANDOM_ITEMS = 1300;
	localparam int DRAIN_CYCLES = CAP + 8;

	// Shadow copy of the list plus the results it still owes
	class list_shadow;
		logic signed [31:0] elems [CAP];
		int                 held;
		rsp_t               pending_rsp [$];
		int                 errors;

		function new();
			held   = 0;
			errors = 0;
		endfunction

		// Open a gap at index at and fill it
		function void insert_at(int at, logic signed [31:0] v);
			for (int i = held; i > at; i--)
				elems[i] = elems[i - 1];
			elems[at] = v;
			held++;
		endfunction

		// Close the gap at index at
		function void remove_at(int at);
			for (int i = at; i + 1 < held; i++)
				elems[i] = elems[i + 1];
			held--;
		endfunction

		// Apply one accepted request and queue the result it must produce
		function void note_request(req_t r);
			rsp_t want;
			bit   full;
			bit   empty;
			int   pos;
			full        = held >= CAP;
			empty       = held == 0;
			pos         = r.position;
			want        = '0;
			want.status = STAT_DONE;
			case (r.operation)
				OP_FRONT, OP_APPEND, OP_AFTER: begin
					if (full)
						want.status = STAT_FULL;
					else if (r.operation == OP_FRONT || empty)
						insert_at(0, r.value);
					else if (r.operation == OP_APPEND)
						insert_at(held, r.value);
					else
						insert_at((pos < held ? pos : held - 1) + 1, r.value);
				end
				OP_READ: begin
					if (pos < held) begin
						want.read_value = elems[pos];
						want.found      = 1'b1;
					end else begin
						want.read_value = -32'sd1;
						want.status     = STAT_NONE;
					end
				end
				OP_DROP_FIRST: begin
					if (empty) want.status = STAT_NONE;
					else remove_at(0);
				end
				OP_DROP_LAST: begin
					if (empty) want.status = STAT_NONE;
					else held--;
				end
				OP_DROP_AT: begin
					if (pos < held) remove_at(pos);
					else want.status = STAT_NONE;
				end
				default: held = 0;
			endcase
			want.count = 7'(held);
			pending_rsp.push_back(want);
		endfunction

		// Compare a transferred result with the oldest one owed
		function void check_response(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%0t: result with none owed: value=%0d found=%0b count=%0d status=%0d",
						$time, got.read_value, got.found, got.count, got.status);
				return;
			end
			want = pending_rsp.pop_front();
			if (got.read_value !== want.read_value || got.found !== want.found ||
					got.count !== want.count || got.status !== want.status) begin
				errors++;
				if (errors <= 10)
					$display({"%0t: result mismatch: expected value=%0d found=%0b count=%0d",
						" status=%0d, got value=%0d found=%0b count=%0d status=%0d"},
						$time, want.read_value, want.found, want.count, want.status,
						got.read_value, got.found, got.count, got.status);
			end
		endfunction
	endclass

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	int         src_idle_pct  = 0;
	int         dst_stall_pct = 0;
	list_shadow shadow        = new();

	indexed_ordered_list_core #(
		.CAPACITY(CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Stall the result side at random
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < dst_stall_pct);
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			shadow.check_response(rsp);
	end

	function automatic req_t mk(op_e_t op, int pos, logic [31:0] v);
		req_t r;
		r.operation = op;
		r.position  = 6'(pos);
		r.value     = v;
		return r;
	endfunction

	// Pick an operation with the given insert weight, positions mostly near the list
	function automatic req_t random_req(int ins_pct);
		int          roll;
		int          top;
		int          pos;
		op_e_t       op;
		logic [31:0] v;
		roll = $urandom_range(0, 99);
		if (roll < ins_pct)
			op = op_e_t'($urandom_range(OP_FRONT, OP_AFTER));
		else if (roll < ins_pct + 15)
			op = OP_READ;
		else if (roll < 99)
			op = op_e_t'($urandom_range(OP_DROP_FIRST, OP_DROP_AT));
		else
			op = OP_CLEAR;
		top = shadow.held < 63 ? shadow.held : 63;
		if ($urandom_range(0, 3) != 0)
			pos = $urandom_range(0, top);
		else
			pos = $urandom_range(0, 63);
		case ($urandom_range(0, 9))
			0: v = 32'h8000_0000;
			1: v = 32'h7fff_ffff;
			default: v = $urandom;
		endcase
		return mk(op, pos, v);
	endfunction

	// Present one request after a random gap and hold it until transferred
	task automatic send_request(input req_t r);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		shadow.note_request(r);
	endtask

	// Run segments that grow, shrink or churn the list
	task automatic run_random(input int n);
		int left;
		int seg;
		int ins_pct;
		left = n;
		while (left > 0) begin
			seg = $urandom_range(40, 160);
			if (seg > left)
				seg = left;
			case ($urandom_range(0, 2))
				0: ins_pct = 80;
				1: ins_pct = 20;
				default: ins_pct = 45;
			endcase
			repeat (seg)
				send_request(random_req(ins_pct));
			left -= seg;
		end
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty list corner cases
		send_request(mk(OP_CLEAR, 0, 32'h0));
		send_request(mk(OP_READ, 0, 32'h1234_5678));
		send_request(mk(OP_DROP_FIRST, 0, 32'h0));
		send_request(mk(OP_DROP_LAST, 0, 32'h0));
		send_request(mk(OP_DROP_AT, 0, 32'h0));
		// Build a short list from every insert flavor and the value extremes
		send_request(mk(OP_AFTER, 63, 32'h7fff_ffff));
		send_request(mk(OP_FRONT, 0, 32'h8000_0000));
		send_request(mk(OP_APPEND, 21, 32'hffff_ffff));
		send_request(mk(OP_AFTER, 0, 32'h0));
		send_request(mk(OP_AFTER, 63, 32'h5555_5555));
		// Reads inside and past the end
		send_request(mk(OP_READ, 0, 32'h0));
		send_request(mk(OP_READ, 4, 32'h0));
		send_request(mk(OP_READ, 5, 32'h0));
		send_request(mk(OP_READ, 63, 32'hffff_ffff));
		// Removes inside and past the end, then an append, a clear and a read of the empty list
		send_request(mk(OP_DROP_AT, 2, 32'h0));
		send_request(mk(OP_DROP_AT, 4, 32'h0));
		send_request(mk(OP_DROP_AT, 63, 32'h0));
		send_request(mk(OP_DROP_FIRST, 42, 32'h0));
		send_request(mk(OP_DROP_LAST, 0, 32'h0));
		send_request(mk(OP_READ, 1, 32'h0));
		send_request(mk(OP_APPEND, 0, 32'haaaa_aaaa));
		send_request(mk(OP_CLEAR, 63, 32'hffff_ffff));
		send_request(mk(OP_READ, 0, 32'h0));

		// Random traffic under each idling pattern
		run_random(RANDOM_ITEMS / 4);
		src_idle_pct  = 66;
		run_random(RANDOM_ITEMS / 4);
		src_idle_pct  = 0;
		dst_stall_pct = 66;
		run_random(RANDOM_ITEMS / 4);
		src_idle_pct  = 14;
		dst_stall_pct = 14;
		run_random(RANDOM_ITEMS / 4);
		req_valid <= 1'b0;

		// Drain and watch for stray results
		while (shadow.pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (shadow.errors == 0)
			$display("tb_indexed_ordered_list_core: done, clean");
		else
			$display("tb_indexed_ordered_list_core: done, errors");
		$finish;
	end

	// Stop a hung run
	initial begin
		#2_000_000;
		$display("tb_indexed_ordered_list_core: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/iol_pkg.sv
hw/rtl/iol_ram.sv
hw/rtl/iol_datapath.sv
hw/rtl/iol_ctrl.sv
hw/rtl/indexed_ordered_list_core.sv
tb/sv/tb_indexed_ordered_list_core.sv
